// ===== rtl/request_frame_deframer_assert.svh =====
// ---------------------------------------------------------------------------
// request_frame_deframer assertion macros
// Concurrent assertion wrappers on clk_i / rst_ni.
// ---------------------------------------------------------------------------
`ifndef REQUEST_FRAME_DEFRAMER_ASSERT_SVH
`define REQUEST_FRAME_DEFRAMER_ASSERT_SVH
`ifndef ASSERT_OFF
`define RFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RFD_ASSERT(lbl, prop, msg)
`define RFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/rfd_pkg.sv =====
// ---------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the request frame deframer.
// ---------------------------------------------------------------------------
`default_nettype none
package rfd_pkg;
  localparam logic [31:0] TagV2          = 32'hFFFF_FFFE;
  localparam logic [31:0] TagBatch       = 32'hFFFF_FFFF;
  localparam logic [31:0] DefaultTimeout = 32'd30000;
  localparam logic [31:0] MaxBatch       = 32'd4096;
  localparam logic [31:0] RstMaxId       = 32'd16777216;
  localparam logic [31:0] RstMaxSql      = 32'd67108864;
  localparam logic [12:0] RstMaxItems    = 13'd4096;

  localparam logic [1:0] CfgMaxId    = 2'd0;
  localparam logic [1:0] CfgMaxSql   = 2'd1;
  localparam logic [1:0] CfgMaxItems = 2'd2;

  localparam logic [2:0] KindHeader = 3'd0;
  localparam logic [2:0] KindStart  = 3'd1;
  localparam logic [2:0] KindPay    = 3'd2;
  localparam logic [2:0] KindEnd    = 3'd3;
  localparam logic [2:0] KindFend   = 3'd4;
  localparam logic [2:0] KindError  = 3'd5;

  localparam logic [1:0] FmtLegacy = 2'd0;
  localparam logic [1:0] FmtV2     = 2'd1;
  localparam logic [1:0] FmtBatch  = 2'd2;

  localparam int unsigned InTdataW  = 8;
  localparam int unsigned OutTdataW = 136;
  localparam int unsigned OutTuserW = 4;

  // result mask bits, listed MSB first; results are emitted from the LSB (hdr) upward
  typedef struct packed {
    logic err;
    logic fend;
    logic iend;
    logic pay;
    logic start;
    logic hdr;
  } mask_t;

  typedef struct packed {
    logic [1:0]  fmt;
    logic        wait_flag;
    logic [31:0] timeout;
    logic [12:0] count;
    logic [11:0] index;
    logic [31:0] id_len;
    logic [31:0] sql_len;
    logic        fsel;
    logic [7:0]  data;
    logic        err_code;
    mask_t       mask;
  } rec_t;
endpackage
`default_nettype wire

// ===== rtl/rfd_front.sv =====
// ---------------------------------------------------------------------------
// rfd_front
// Byte parser: tracks the frame phase and turns each byte into at most one record.
// ---------------------------------------------------------------------------
`default_nettype none
module rfd_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_fire_i,
  input  wire logic          cmd_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_idx_i,
  input  wire logic [31:0]   cfg_data_i,
  output rfd_pkg::rec_t      rec_o,
  output logic               push_o
);
  import rfd_pkg::*;

  typedef enum logic [2:0] {
    PhTag, PhV2Hdr, PhLegSql, PhCount, PhItemHdr, PhId, PhSql, PhError
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [4:0]  hbc_q, hbc_d;
  logic [31:0] shift_q, shift_d;
  logic [1:0]  fmt_q, fmt_d;
  logic        wait_q, wait_d;
  logic [31:0] tmo_q, tmo_d;
  logic [12:0] total_q, total_d;
  logic [11:0] done_q, done_d;
  logic [31:0] idl_q, idl_d, sql_q, sql_d, left_q, left_d;
  logic [31:0] max_id_q, max_sql_q;
  logic [12:0] max_items_q;

  logic [31:0] sh;
  logic [4:0]  hc;
  logic        do_start, with_hdr, do_finish;
  mask_t       m;
  logic        fsel, ecode;

  always_comb begin
    phase_d = phase_q; hbc_d = hbc_q; shift_d = shift_q; fmt_d = fmt_q;
    wait_d = wait_q; tmo_d = tmo_q; total_d = total_q; done_d = done_q;
    idl_d = idl_q; sql_d = sql_q; left_d = left_q;
    m = '0; fsel = 1'b0; ecode = 1'b0;
    do_start = 1'b0; with_hdr = 1'b0; do_finish = 1'b0;
    sh = {shift_q[23:0], byte_i};
    hc = hbc_q + 5'd1;
    if (cmd_i) begin
      phase_d = PhTag;
      hbc_d = '0;
    end else if (phase_q == PhError) begin
    end else if (phase_q == PhId || phase_q == PhSql) begin
      m.pay = 1'b1;
      fsel = (phase_q == PhSql);
      left_d = left_q - 32'd1;
      if (left_d == '0) begin
        if (!fsel && sql_q != '0) begin
          phase_d = PhSql;
          left_d = sql_q;
        end else begin
          do_finish = 1'b1;
        end
      end
    end else begin
      shift_d = sh;
      hbc_d = hc;
      case (phase_q)
        PhTag: begin
          if (hc[1:0] == 2'd0) begin
            wait_d = 1'b0; tmo_d = DefaultTimeout; total_d = '0; done_d = '0;
            idl_d = '0; sql_d = '0; left_d = '0; hbc_d = '0;
            if (sh == TagV2) begin
              fmt_d = FmtV2; total_d = 13'd1; phase_d = PhV2Hdr;
            end else if (sh == TagBatch) begin
              fmt_d = FmtBatch; phase_d = PhCount;
            end else begin
              fmt_d = FmtLegacy; total_d = 13'd1; idl_d = sh; phase_d = PhLegSql;
            end
          end
        end
        PhLegSql: begin
          if (hc[1:0] == 2'd0) begin
            sql_d = sh; hbc_d = '0; do_start = 1'b1; with_hdr = 1'b1;
          end
        end
        PhV2Hdr: begin
          if (hc == 5'd4) wait_d = sh[0];
          else if (hc == 5'd8) tmo_d = sh;
          else if (hc == 5'd12) idl_d = sh;
          else if (hc >= 5'd16) begin
            sql_d = sh; hbc_d = '0; do_start = 1'b1; with_hdr = 1'b1;
          end
        end
        PhCount: begin
          if (hc[1:0] == 2'd0) begin
            hbc_d = '0;
            if (sh == '0 || sh > {19'd0, max_items_q} || sh > MaxBatch) begin
              m.err = 1'b1; ecode = 1'b1; phase_d = PhError;
            end else begin
              total_d = sh[12:0]; done_d = '0; m.hdr = 1'b1; phase_d = PhItemHdr;
            end
          end
        end
        PhItemHdr: begin
          if (hc == 5'd4) begin
            idl_d = sh; sql_d = '0;
          end else if (hc >= 5'd8) begin
            sql_d = sh; hbc_d = '0; do_start = 1'b1;
          end
        end
        default: begin
          phase_d = PhTag; hbc_d = '0;
        end
      endcase
    end
    if (do_start) begin
      if (idl_d > max_id_q || sql_d > max_sql_q) begin
        m.err = 1'b1; phase_d = PhError;
      end else begin
        m.hdr = with_hdr;
        m.start = 1'b1;
        if (idl_d != '0) begin
          phase_d = PhId; left_d = idl_d;
        end else if (sql_d != '0) begin
          phase_d = PhSql; left_d = sql_d;
        end else begin
          do_finish = 1'b1;
        end
      end
    end
    if (do_finish) begin
      m.iend = 1'b1;
      if ({1'b0, done_q} + 13'd1 >= total_d) begin
        m.fend = 1'b1; phase_d = PhTag;
      end else begin
        done_d = done_q + 12'd1; phase_d = PhItemHdr;
      end
      hbc_d = '0;
    end
  end

  // all results of one byte share the context; index is taken before increment
  always_comb begin
    rec_o.fmt = fmt_d;
    rec_o.wait_flag = wait_d;
    rec_o.timeout = tmo_d;
    rec_o.count = total_d;
    rec_o.index = done_q;
    rec_o.id_len = idl_d;
    rec_o.sql_len = sql_d;
    rec_o.fsel = fsel;
    rec_o.data = m.pay ? byte_i : 8'd0;
    rec_o.err_code = ecode;
    rec_o.mask = m;
  end
  assign push_o = in_fire_i && (m != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhTag; hbc_q <= '0; shift_q <= '0; fmt_q <= FmtLegacy;
      wait_q <= 1'b0; tmo_q <= DefaultTimeout; total_q <= '0; done_q <= '0;
      idl_q <= '0; sql_q <= '0; left_q <= '0;
      max_id_q <= RstMaxId; max_sql_q <= RstMaxSql; max_items_q <= RstMaxItems;
    end else begin
      if (in_fire_i) begin
        phase_q <= phase_d; hbc_q <= hbc_d; shift_q <= shift_d; fmt_q <= fmt_d;
        wait_q <= wait_d; tmo_q <= tmo_d; total_q <= total_d; done_q <= done_d;
        idl_q <= idl_d; sql_q <= sql_d; left_q <= left_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgMaxId:    max_id_q <= cfg_data_i;
          CfgMaxSql:   max_sql_q <= cfg_data_i;
          CfgMaxItems: max_items_q <= cfg_data_i[12:0];
          default: ;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rfd_queue.sv =====
// ---------------------------------------------------------------------------
// rfd_queue
// Two-entry record queue between parser and result sequencer.
// ---------------------------------------------------------------------------
`default_nettype none
module rfd_queue (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  rfd_pkg::rec_t  rec_i,
  output logic           full_o,
  output logic           valid_o,
  input  wire logic      pop_i,
  output rfd_pkg::rec_t  rec_o
);
  import rfd_pkg::*;

  rec_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign rec_o   = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/rfd_back.sv =====
// ---------------------------------------------------------------------------
// rfd_back
// Result sequencer: expands one record into its result beats in order.
// ---------------------------------------------------------------------------
`default_nettype none
`include "request_frame_deframer_assert.svh"
module rfd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  input  rfd_pkg::rec_t      q_rec_i,
  output logic               q_pop_o,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [rfd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [rfd_pkg::OutTuserW-1:0] m_axis_tuser,
  output logic               m_axis_tlast
);
  import rfd_pkg::*;

  rec_t  cur_q;
  logic  vld_q;
  logic [5:0] mk, low, rest;
  logic [2:0] kind;
  logic  fire;

  assign mk   = cur_q.mask;
  assign low  = mk & (~mk + 6'd1);
  assign rest = mk & ~low;

  always_comb begin
    case (low)
      6'b000001: kind = KindHeader;
      6'b000010: kind = KindStart;
      6'b000100: kind = KindPay;
      6'b001000: kind = KindEnd;
      6'b010000: kind = KindFend;
      default:   kind = KindError;
    endcase
  end

  assign fire    = vld_q && m_axis_tready;
  assign q_pop_o = q_valid_i && (!vld_q || (fire && rest == '0));

  assign m_axis_tvalid = vld_q;
  assign m_axis_tlast  = rest == '0;
  assign m_axis_tuser  = {(kind == KindPay) & cur_q.fsel, kind};
  assign m_axis_tdata  = {3'd0,
                          (kind == KindError) & cur_q.err_code,
                          (kind == KindPay) ? cur_q.data : 8'd0,
                          cur_q.sql_len, cur_q.id_len, cur_q.index, cur_q.count,
                          cur_q.timeout, cur_q.wait_flag, cur_q.fmt};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      cur_q <= '0;
    end else if (q_pop_o) begin
      vld_q <= 1'b1;
      cur_q <= q_rec_i;
    end else if (fire) begin
      cur_q.mask <= rest;
      vld_q <= rest != '0;
    end
  end

  `RFD_ASSERT(a_mask_live, vld_q |-> (mk != '0), "held record has no results left")
  `RFD_ASSERT(a_last_one, (vld_q && m_axis_tlast) |-> $onehot(mk), "tlast with results left")
  `RFD_ASSERT(a_drain, (fire && !m_axis_tlast && !q_pop_o) |=> (vld_q && $countones(mk) == $countones($past(mk)) - 1), "beat not retired")
endmodule
`default_nettype wire

// ===== rtl/request_frame_deframer.sv =====
// ---------------------------------------------------------------------------
// request_frame_deframer
// Parses legacy, v2 and batch request frames from a byte stream.
// ---------------------------------------------------------------------------
// channel  dir  tdata                     tuser
// s_axis   in   [7:0] stream_byte         [0] command (1 = flush)
// m_axis   out  fmt,wait,timeout,count,   [2:0] result_kind, [3] field_select
//               index,id,sql,data,err     tlast = last result of the byte
// cfg      in   cfg_idx_i / cfg_data_i    write on cfg_we_i
// One byte accepted per clock unless the queue is full; n results of a byte take n beats.
// Results of a byte pass the record queue, then the sequencer's holding register.
// Parser and sequencer are split by a 2-entry record queue; s_axis_tready
// drops only when that queue is full. Reset clears all but queue storage, limits to defaults.
// ---------------------------------------------------------------------------
`default_nettype none
module request_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [rfd_pkg::InTdataW-1:0] s_axis_tdata, // [7:0] stream_byte
  input  wire logic        s_axis_tuser,                  // [0] command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [1:0] frame_format, [2] wait_terminal, [34:3] term_timeout, [47:35] frame_items,
  // [59:48] item_index, [91:60] id_length, [123:92] sql_length,
  // [131:124] data_byte, [132] error_code
  output logic [rfd_pkg::OutTdataW-1:0] m_axis_tdata,
  output logic [rfd_pkg::OutTuserW-1:0] m_axis_tuser,   // [2:0] result_kind, [3] field_select
  output logic             m_axis_tlast,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import rfd_pkg::*;

  rec_t push_rec, pop_rec;
  logic push, full, qv, pop;

  assign s_axis_tready = !full;

  rfd_front u_front (
    .clk_i, .rst_ni,
    .in_fire_i (s_axis_tvalid && s_axis_tready),
    .cmd_i     (s_axis_tuser),
    .byte_i    (s_axis_tdata),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .rec_o     (push_rec),
    .push_o    (push)
  );

  rfd_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .rec_i (push_rec), .full_o (full),
    .valid_o (qv), .pop_i (pop), .rec_o (pop_rec)
  );

  rfd_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i (qv), .q_rec_i (pop_rec), .q_pop_o (pop),
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );
endmodule
`default_nettype wire
